>>> rtl/core/lifeg_pkg.sv
// ----------------------------------------------------------------------------
// lifeg_pkg
// Shared types and constants for the toroidal life grid engine.
// ----------------------------------------------------------------------------
package lifeg_pkg;

	// operation carried by each input transaction
	typedef enum logic [1:0] {
		MODE_TOGGLE = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_STEP   = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	// neighbor count, 0..8
	localparam int unsigned NCNT_W = 4;
	typedef logic [NCNT_W-1:0] ncnt_t;

	// B3/S23 rule
	localparam ncnt_t BIRTH_N = ncnt_t'(3);
	localparam ncnt_t KEEP_N  = ncnt_t'(2);

endpackage

>>> rtl/core/life_automaton_grid_engine.sv
// ----------------------------------------------------------------------------
// life_automaton_grid_engine
// Toroidal B3/S23 grid held one row per RAM word, swept by a shared row unit.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; in_stall stays high until it is done,
// while a finished result may still wait on the output register. Toggle and
// read go from accept through the RD and CAP states to DONE. Clear writes
// zero rows one per cycle. A generation streams the rows through the single
// RAM read port into a three-row window and writes one new row per cycle
// through the row-rule unit. After reset a clearing pass writes every row
// to zero before the first transaction is taken.
module life_automaton_grid_engine #(
	parameter int GRID_W = 64,
	parameter int GRID_H = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [5:0] row,
	input  logic [5:0] col,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       cell_before,
	output logic       cell_after
);

	localparam int RW   = $clog2(GRID_H);
	localparam int CW   = $clog2(GRID_W);
	localparam int RXW  = ($clog2(GRID_H + 1) > 6) ? $clog2(GRID_H + 1) : 6;
	localparam int CXW  = ($clog2(GRID_W + 1) > 6) ? $clog2(GRID_W + 1) : 6;
	localparam int CNTW = $clog2(GRID_H + 2);

	typedef enum logic [6:0] {
		ST_INIT = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_RD   = 7'b0000100,
		ST_CAP  = 7'b0001000,
		ST_CLR  = 7'b0010000,
		ST_GEN  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	lifeg_pkg::mode_t mode_q;
	logic [RW-1:0]    row_ix_q;
	logic [CW-1:0]    col_ix_q;
	logic             ok_q;
	logic             before_q;
	logic             after_q;
	logic [RW-1:0]    clr_cnt_q;
	logic [CNTW-1:0]  rd_cnt_q;
	logic [CNTW-1:0]  ridx_q;
	logic             rvld_q;
	logic             tail_q;
	logic [GRID_W-1:0] win_up_q;
	logic [GRID_W-1:0] win_mid_q;
	logic [GRID_W-1:0] row0_q;
	logic             out_valid_q;
	logic             out_before_q;
	logic             out_after_q;

	logic [RXW-1:0]    row_x;
	logic [CXW-1:0]    col_x;
	logic              addr_ok;
	logic              accept;
	logic              rd_issue;
	logic              gen_we;
	logic [RW-1:0]     gen_wrow;
	logic [GRID_W-1:0] rule_dn;
	logic [GRID_W-1:0] rule_nxt;
	logic              out_load;
	logic              cap_bit;

	logic              ram_we;
	logic [RW-1:0]     ram_waddr;
	logic [GRID_W-1:0] ram_wdata;
	logic [RW-1:0]     ram_raddr;
	logic [GRID_W-1:0] ram_rdata;

	assign row_x   = RXW'(row);
	assign col_x   = CXW'(col);
	assign addr_ok = (row_x < RXW'(GRID_H)) && (col_x < CXW'(GRID_W));

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign rd_issue = (state_q == ST_GEN) && (rd_cnt_q <= CNTW'(GRID_H));
	assign gen_we   = (rvld_q && (ridx_q >= CNTW'(2))) || tail_q;
	assign gen_wrow = tail_q ? RW'(GRID_H - 1) : RW'(ridx_q - CNTW'(2));
	assign rule_dn  = tail_q ? row0_q : ram_rdata;
	assign cap_bit  = ok_q && ram_rdata[col_ix_q];
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	lifeg_row_rule #(
		.GRID_W (GRID_W)
	) u_rule (
		.up  (win_up_q),
		.mid (win_mid_q),
		.dn  (rule_dn),
		.nxt (rule_nxt)
	);

	lifeg_ram #(
		.WIDTH (GRID_W),
		.DEPTH (GRID_H)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			ST_INIT, ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
			end
			ST_RD: begin
				ram_raddr = row_ix_q;
			end
			ST_CAP: begin
				ram_we    = (mode_q == lifeg_pkg::MODE_TOGGLE) && ok_q;
				ram_waddr = row_ix_q;
				ram_wdata = ram_rdata ^ (GRID_W'(1) << col_ix_q);
			end
			ST_GEN: begin
				ram_raddr = (rd_cnt_q == '0) ? RW'(GRID_H - 1) : RW'(rd_cnt_q - CNTW'(1));
				ram_we    = gen_we;
				ram_waddr = gen_wrow;
				ram_wdata = rule_nxt;
			end
			default: begin
			end
		endcase
	end

	// window and row-0 copy carry payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_GEN && rvld_q) begin
			win_up_q  <= win_mid_q;
			win_mid_q <= ram_rdata;
			if (ridx_q == CNTW'(1)) begin
				row0_q <= ram_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			mode_q       <= lifeg_pkg::MODE_READ;
			row_ix_q     <= '0;
			col_ix_q     <= '0;
			ok_q         <= 1'b0;
			before_q     <= 1'b0;
			after_q      <= 1'b0;
			clr_cnt_q    <= '0;
			rd_cnt_q     <= '0;
			ridx_q       <= '0;
			rvld_q       <= 1'b0;
			tail_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_before_q <= 1'b0;
			out_after_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_before_q <= before_q;
				out_after_q  <= after_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT: begin
					clr_cnt_q <= clr_cnt_q + RW'(1);
					if (clr_cnt_q == RW'(GRID_H - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						mode_q   <= lifeg_pkg::mode_t'(mode);
						ok_q     <= addr_ok;
						row_ix_q <= addr_ok ? RW'(row_x) : '0;
						col_ix_q <= addr_ok ? CW'(col_x) : '0;
						state_q  <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					before_q  <= cap_bit;
					clr_cnt_q <= '0;
					rd_cnt_q  <= '0;
					rvld_q    <= 1'b0;
					tail_q    <= 1'b0;
					case (mode_q)
						lifeg_pkg::MODE_TOGGLE: begin
							after_q <= ok_q && !ram_rdata[col_ix_q];
							state_q <= ST_DONE;
						end
						lifeg_pkg::MODE_CLEAR: begin
							after_q <= 1'b0;
							state_q <= ST_CLR;
						end
						lifeg_pkg::MODE_STEP: begin
							after_q <= 1'b0;
							state_q <= ST_GEN;
						end
						default: begin
							after_q <= cap_bit;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + RW'(1);
					if (clr_cnt_q == RW'(GRID_H - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_GEN: begin
					rvld_q <= rd_issue;
					ridx_q <= rd_cnt_q;
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + CNTW'(1);
					end
					if (rvld_q && ridx_q == CNTW'(GRID_H)) begin
						tail_q <= 1'b1;
					end
					// pick up the addressed cell as its new row goes by
					if (gen_we && ok_q && gen_wrow == row_ix_q) begin
						after_q <= rule_nxt[col_ix_q];
					end
					if (tail_q) begin
						tail_q  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_before = out_before_q;
	assign cell_after  = out_after_q;

endmodule

>>> rtl/core/lifeg_ram.sv
// ----------------------------------------------------------------------------
// lifeg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lifeg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/lifeg_row_rule.sv
// ----------------------------------------------------------------------------
// lifeg_row_rule
// Next-generation row from three old rows, columns wrap at both edges.
// ----------------------------------------------------------------------------
module lifeg_row_rule #(
	parameter int GRID_W = 64
) (
	input  logic [GRID_W-1:0] up,
	input  logic [GRID_W-1:0] mid,
	input  logic [GRID_W-1:0] dn,
	output logic [GRID_W-1:0] nxt
);

	for (genvar c = 0; c < GRID_W; c++) begin : g_col
		localparam int L = (c == 0) ? GRID_W - 1 : c - 1;
		localparam int R = (c == GRID_W - 1) ? 0 : c + 1;

		lifeg_pkg::ncnt_t n;

		assign n = lifeg_pkg::ncnt_t'(up[L]) + lifeg_pkg::ncnt_t'(up[c])
			+ lifeg_pkg::ncnt_t'(up[R]) + lifeg_pkg::ncnt_t'(mid[L])
			+ lifeg_pkg::ncnt_t'(mid[R]) + lifeg_pkg::ncnt_t'(dn[L])
			+ lifeg_pkg::ncnt_t'(dn[c]) + lifeg_pkg::ncnt_t'(dn[R]);

		assign nxt[c] = (n == lifeg_pkg::BIRTH_N) || (mid[c] && (n == lifeg_pkg::KEEP_N));
	end

endmodule
